// ===== rtl/ptrt_pkg.sv =====
// package for the prefix traffic rate table: types, constants, status codes
package ptrt_pkg;

    localparam int ENTRIES   = 32;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int RATE_W    = 40;
    localparam int DIV_W     = 64;
    localparam int DIV_STEPS = 64;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    localparam logic [31:0]     Q8_SCALE = 32'd250000;
    localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_DEL  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;
    localparam logic [1:0] OP_RECALC = 2'd3;

    localparam logic [2:0] ST_MATCH  = 3'd0;
    localparam logic [2:0] ST_INSERT = 3'd1;
    localparam logic [2:0] ST_NOMATCH = 3'd2;
    localparam logic [2:0] ST_FULL   = 3'd3;
    localparam logic [2:0] ST_RECALC = 3'd4;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] dest_ip;
        logic [31:0] ip_mask;
        logic [15:0] byte_count;
        logic [31:0] now_us;
    } req_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [RATE_W-1:0] rate_q8;
        logic [5:0]        entry_count;
    } rsp_t;

    // one table entry
    typedef struct packed {
        logic [31:0]       addr;
        logic [31:0]       mask;
        logic [31:0]       total;
        logic [31:0]       total_prev;
        logic [31:0]       stamp;
        logic [RATE_W-1:0] rate;
    } entry_t;

    // row-wide command from the controller to every cell
    typedef struct packed {
        logic shift_down;  // cells at or above the hit index take the upper neighbor
        logic add_bytes;   // first matching cell adds bytes
        logic insert;      // cell at the entry count loads a new entry
        logic rotate;      // each cell takes upper neighbor; top and last used cell take feedback
    } cell_cmd_t;

endpackage

// ===== rtl/ptrt_cell.sv =====
// one table slot: entry storage, prefix compare, byte add, load, shift and rotate
module ptrt_cell (
    input  logic                aclk,
    input  ptrt_pkg::cell_cmd_t cmd,
    input  logic                shift_en,
    input  logic                add_en,
    input  logic                load_en,
    input  ptrt_pkg::entry_t    upper,
    input  ptrt_pkg::entry_t    load_data,
    input  logic [31:0]         key,
    input  logic [15:0]         add_val,
    output ptrt_pkg::entry_t    cur,
    output logic                hit
);
    import ptrt_pkg::*;

    entry_t ent_reg;
    entry_t ent_next;

    always_comb begin
        ent_next = ent_reg;
        if (cmd.rotate || shift_en) begin
            ent_next = upper;
        end else if (load_en) begin
            ent_next = load_data;
        end else if (add_en) begin
            ent_next.total = ent_reg.total + {16'd0, add_val};
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end

    assign cur = ent_reg;
    assign hit = ((ent_reg.addr & ent_reg.mask) == key);
endmodule

// ===== rtl/ptrt_rate_div.sv =====
// bit-serial rate divider: (db * 250000) / dt, saturated to 40 bits
module ptrt_rate_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [31:0]                 db,
    input  logic [31:0]                 dt,
    output logic                        done,
    output logic [ptrt_pkg::RATE_W-1:0] rate
);
    import ptrt_pkg::*;

    logic [DIV_W-1:0]  num_reg;
    logic [DIV_W-1:0]  num_next;
    logic [32:0]       rem_reg;
    logic [32:0]       rem_next;
    logic [31:0]       den_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [STEP_W-1:0] cnt_next;
    logic              busy_reg;
    logic              busy_next;
    logic              zero_reg;
    logic [32:0]       trial;
    logic [32:0]       diff;

    always_comb begin
        trial     = {rem_reg[31:0], num_reg[DIV_W-1]};
        diff      = trial - {1'b0, den_reg};
        num_next  = num_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = STEP_W'(DIV_STEPS);
            rem_next  = '0;
            num_next  = 64'(db) * 64'(Q8_SCALE);
        end else if (busy_reg) begin
            if (!diff[32]) begin
                rem_next = diff;
                num_next = {num_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = trial;
                num_next = {num_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        if (start) begin
            den_reg  <= dt;
            zero_reg <= (dt == 32'd0);
        end
    end

    assign done = busy_reg && (cnt_reg == STEP_W'(1)) && !start;
    always_comb begin
        if (zero_reg || (|num_next[DIV_W-1:RATE_W])) begin
            rate = RATE_MAX;
        end else begin
            rate = num_next[RATE_W-1:0];
        end
    end
endmodule

// ===== rtl/prefix_traffic_rate_table.sv =====
// top level: row of prefix cells, lookup priority, controller, rate divider
// add, delete and read pass through the lookup, execute and output states from request to result
// recompute runs the one shared divider once per valid entry and rotates the row after each division
// a new request is taken only in idle, after the previous result has entered the output register
// reset: synchronous active low, clears the entry count and control state
// table contents are not cleared, slots above the count are never read
module prefix_traffic_rate_table (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ptrt_pkg::req_t    s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ptrt_pkg::rsp_t    m_data
);
    import ptrt_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOOK = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;
    localparam logic [2:0] S_ROT  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]       state_reg, state_next;
    req_t             req_reg;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0] rot_reg, rot_next;
    logic [ENTRIES-1:0] hit_reg;
    logic             m_valid_reg, m_valid_next;
    rsp_t             m_data_reg, m_data_next;
    rsp_t             res_reg, res_next;

    entry_t           cur [ENTRIES];
    logic [ENTRIES-1:0] hit_raw;
    logic [ENTRIES-1:0] first_hit;
    logic             any_hit;
    logic [IDX_W-1:0] hit_idx;
    cell_cmd_t        cmd;
    entry_t           load_data;
    entry_t           fb;
    logic [31:0]      key;
    logic             div_start, div_done;
    logic [RATE_W-1:0] div_rate;

    assign key = req_reg.dest_ip & req_reg.ip_mask;

    // first valid hit in slot order
    always_comb begin
        first_hit = '0;
        any_hit   = 1'b0;
        hit_idx   = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (hit_reg[i] && !any_hit) begin
                first_hit[i] = 1'b1;
                any_hit      = 1'b1;
                hit_idx      = IDX_W'(i);
            end
        end
    end

    always_comb begin
        load_data            = '0;
        load_data.addr       = req_reg.dest_ip;
        load_data.mask       = req_reg.ip_mask;
        load_data.total      = {16'd0, req_reg.byte_count};
        load_data.stamp      = req_reg.now_us;
        fb                   = cur[0];
        fb.rate              = div_rate;
        fb.total_prev        = cur[0].total;
        fb.stamp             = req_reg.now_us;
    end

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            entry_t up;
            logic   sh, ld, ad;
            if (g == ENTRIES - 1) begin : g_top
                assign up = cmd.rotate ? fb : cur[g];
            end else begin : g_mid
                assign up = (cmd.rotate && (CNT_W'(g + 1) == used_reg)) ? fb : cur[g + 1];
            end
            assign sh = cmd.shift_down && (IDX_W'(g) >= hit_idx);
            assign ld = cmd.insert && (used_reg == CNT_W'(g));
            assign ad = cmd.add_bytes && first_hit[g];
            ptrt_cell u_cell (
                .aclk      (aclk),
                .cmd       (cmd),
                .shift_en  (sh),
                .add_en    (ad),
                .load_en   (ld),
                .upper     (up),
                .load_data (load_data),
                .key       (key),
                .add_val   (req_reg.byte_count),
                .cur       (cur[g]),
                .hit       (hit_raw[g])
            );
        end
    endgenerate

    ptrt_rate_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .db      (cur[0].total - cur[0].total_prev),
        .dt      (req_reg.now_us - cur[0].stamp),
        .done    (div_done),
        .rate    (div_rate)
    );

    always_comb begin
        state_next   = state_reg;
        used_next    = used_reg;
        rot_next     = rot_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        res_next     = res_reg;
        cmd          = '0;
        div_start    = 1'b0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = (s_data.op == OP_RECALC) ? S_DIV : S_LOOK;
                    rot_next   = '0;
                end
            end
            S_LOOK: begin
                state_next = S_EXEC;
            end
            S_EXEC: begin
                res_next.rate_q8 = '0;
                if (any_hit) begin
                    res_next.status  = ST_MATCH;
                    res_next.rate_q8 = cur[hit_idx].rate;
                    if (req_reg.op == OP_ADD) begin
                        cmd.add_bytes = 1'b1;
                    end else if (req_reg.op == OP_DEL) begin
                        cmd.shift_down = 1'b1;
                        used_next      = used_reg - 1'b1;
                    end
                end else if (req_reg.op == OP_ADD) begin
                    if (used_reg < CNT_W'(ENTRIES)) begin
                        cmd.insert      = 1'b1;
                        used_next       = used_reg + 1'b1;
                        res_next.status = ST_INSERT;
                    end else begin
                        res_next.status = ST_FULL;
                    end
                end else begin
                    res_next.status = ST_NOMATCH;
                end
                res_next.entry_count = 6'(used_next);
                state_next = S_OUT;
            end
            S_DIV: begin
                if (rot_reg == used_reg) begin
                    res_next.status      = ST_RECALC;
                    res_next.rate_q8     = '0;
                    res_next.entry_count = 6'(used_reg);
                    state_next           = S_OUT;
                end else begin
                    div_start  = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT: begin
                if (div_done) begin
                    state_next = S_ROT;
                end
            end
            S_ROT: begin
                cmd.rotate = 1'b1;
                rot_next   = rot_reg + 1'b1;
                state_next = S_DIV;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            used_reg    <= '0;
            rot_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            rot_reg     <= rot_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
        res_reg    <= res_next;
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
        for (int i = 0; i < ENTRIES; i++) begin
            hit_reg[i] <= hit_raw[i] && (CNT_W'(i) < used_reg);
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= CNT_W'(ENTRIES))
        else $error("entry count beyond table size");
    a_one_req: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_ready)
        else $error("request taken while busy");
    a_div_only_recalc: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> (req_reg.op == OP_RECALC))
        else $error("divider started outside recompute");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed while waiting");
`endif
endmodule
